// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared widths, action codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPW  = 16;            // operand width
  localparam int PRW  = 2 * OPW;       // cross-product width
  localparam int SW   = 2 * OPW + 1;   // sum / reduction width
  localparam int RESW = 33;            // result field width
  localparam int CW   = $clog2(SW + 1);

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    DS_MOD = 2'd0,
    DS_NUM = 2'd1,
    DS_DEN = 2'd2
  } dsel_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       form;
    logic       div_start;
    dsel_t      div_sel;
    logic       eu_adv;
    logic       cap_num;
    logic       cap_den;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic div_idle;
    logic rem_zero;
  } sts_t;

endpackage

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [rau_pkg::SW-1:0]  dividend,
  input  logic [rau_pkg::SW-1:0]  divisor,
  output logic [rau_pkg::SW-1:0]  quo,
  output logic [rau_pkg::SW-1:0]  rem,
  output logic                    idle
);
  import rau_pkg::*;

  logic [SW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [CW-1:0] cnt_r;
  logic [SW:0]   trial;
  logic [SW+1:0] diff;
  logic          ge;

  assign trial = {rem_r, quo_r[SW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = !diff[SW+1];

  always_comb begin
    rem_nxt = ge ? diff[SW-1:0] : trial[SW-1:0];
    quo_nxt = {quo_r[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(SW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign idle = (cnt_r == '0);

endmodule

// ===== hdl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// operand registers, shared multiplier, euclid registers and result registers
// ----------------------------------------------------------------------------
module rau_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rau_pkg::cmd_t                 cmd,
  output rau_pkg::sts_t                 sts,
  input  logic [2:0]                    in_action,
  input  logic signed [rau_pkg::OPW-1:0] in_a_num,
  input  logic signed [rau_pkg::OPW-1:0] in_a_den,
  input  logic signed [rau_pkg::OPW-1:0] in_b_num,
  input  logic signed [rau_pkg::OPW-1:0] in_b_den,
  output logic signed [rau_pkg::RESW-1:0] res_num,
  output logic signed [rau_pkg::RESW-1:0] res_den,
  output logic                          is_less,
  output logic                          is_equal,
  output logic                          status
);
  import rau_pkg::*;

  logic [2:0]            act_r;
  logic signed [OPW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PRW-1:0] m0_r, m1_r, m2_r;
  logic signed [OPW-1:0] ma, mb;
  logic signed [PRW-1:0] prod;
  logic signed [SW-1:0]  n_c, d_c;
  logic [SW-1:0]         nmag_c, dmag_c;
  logic                  arith, is_cmp;
  logic                  nneg_r, dneg_r, kodd_r, gneg, flip_n, flip_d;
  logic [SW-1:0]         nmag_r, dmag_r, x_r, y_r, dvd;
  logic [SW-1:0]         quo, rem, qn_c, qd_c;
  logic                  div_idle;
  logic signed [RESW-1:0] res_num_r, res_den_r;
  logic                  less_r, equal_r, status_r;

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (y_r),
    .quo      (quo),
    .rem      (rem),
    .idle     (div_idle)
  );

  // shared multiplier, operands picked by step
  always_comb begin
    case (cmd.mul_step)
      2'd0: begin
        ma = an_r;
        mb = (act_r == ACT_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        ma = ad_r;
        mb = bn_r;
      end
      default: begin
        ma = ad_r;
        mb = bd_r;
      end
    endcase
  end
  assign prod = PRW'(ma) * PRW'(mb);

  always_comb begin
    unique case (act_r)
      ACT_ADD: begin
        n_c = SW'(m0_r) + SW'(m1_r);
        d_c = SW'(m2_r);
      end
      ACT_SUB: begin
        n_c = SW'(m0_r) - SW'(m1_r);
        d_c = SW'(m2_r);
      end
      ACT_MUL: begin
        n_c = SW'(m0_r);
        d_c = SW'(m2_r);
      end
      ACT_DIV: begin
        n_c = SW'(m0_r);
        d_c = SW'(m1_r);
      end
      default: begin
        n_c = '0;
        d_c = '0;
      end
    endcase
  end

  assign arith  = (act_r == ACT_ADD) || (act_r == ACT_SUB) ||
                  (act_r == ACT_MUL) || (act_r == ACT_DIV);
  assign is_cmp = (act_r == ACT_CMP);
  assign nmag_c = n_c[SW-1] ? SW'(-n_c) : SW'(n_c);
  assign dmag_c = d_c[SW-1] ? SW'(-d_c) : SW'(d_c);

  always_comb begin
    case (cmd.div_sel)
      DS_NUM:  dvd = nmag_r;
      DS_DEN:  dvd = dmag_r;
      default: dvd = x_r;
    endcase
  end

  // divisor sign follows parity of the euclid step count
  assign gneg   = kodd_r ? dneg_r : nneg_r;
  assign flip_n = nneg_r != gneg;
  assign flip_d = dneg_r != gneg;
  assign qn_c   = flip_n ? (~quo + 1'b1) : quo;
  assign qd_c   = flip_d ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      an_r  <= in_a_num;
      ad_r  <= in_a_den;
      bn_r  <= in_b_num;
      bd_r  <= in_b_den;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        2'd0:    m0_r <= prod;
        2'd1:    m1_r <= prod;
        default: m2_r <= prod;
      endcase
    end
    if (cmd.form) begin
      nneg_r    <= n_c[SW-1];
      dneg_r    <= d_c[SW-1];
      nmag_r    <= nmag_c;
      dmag_r    <= dmag_c;
      x_r       <= nmag_c;
      y_r       <= dmag_c;
      kodd_r    <= 1'b1;
      res_num_r <= '0;
      res_den_r <= '0;
      less_r    <= is_cmp && (m0_r < m1_r);
      equal_r   <= is_cmp && (m0_r == m1_r);
      status_r  <= arith && (d_c == '0);
    end
    if (cmd.eu_adv) begin
      x_r    <= y_r;
      y_r    <= rem;
      kodd_r <= !kodd_r;
    end
    if (cmd.cap_num) begin
      res_num_r <= RESW'($signed(qn_c));
    end
    if (cmd.cap_den) begin
      res_den_r <= RESW'($signed(qd_c));
    end
  end

  assign sts.early    = !arith || (d_c == '0);
  assign sts.div_idle = div_idle;
  assign sts.rem_zero = (rem == '0);

  assign res_num  = res_num_r;
  assign res_den  = res_den_r;
  assign is_less  = less_r;
  assign is_equal = equal_r;
  assign status   = status_r;

endmodule

// ===== hdl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: multiply steps, fraction forming, euclid loop, final divides
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output rau_pkg::cmd_t cmd,
  input  rau_pkg::sts_t sts
);
  import rau_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_FORM   = 6'b000100,
    S_DSTART = 6'b001000,
    S_DRUN   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  dsel_t      phase_r, phase_nxt;
  logic [1:0] mstep_r, mstep_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    mstep_nxt = mstep_r;
    cmd       = '0;
    cmd.mul_step = mstep_r;
    cmd.div_sel  = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          mstep_nxt = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (mstep_r == 2'd2) begin
          state_nxt = S_FORM;
        end else begin
          mstep_nxt = mstep_r + 2'd1;
        end
      end
      S_FORM: begin
        cmd.form  = 1'b1;
        phase_nxt = DS_MOD;
        state_nxt = sts.early ? S_DONE : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DRUN;
      end
      S_DRUN: begin
        if (sts.div_idle) begin
          state_nxt = S_DSTART;
          unique case (phase_r)
            DS_MOD: begin
              if (sts.rem_zero) begin
                phase_nxt = DS_NUM;
              end else begin
                cmd.eu_adv = 1'b1;
              end
            end
            DS_NUM: begin
              cmd.cap_num = 1'b1;
              phase_nxt   = DS_DEN;
            end
            default: begin
              cmd.cap_den = 1'b1;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= DS_MOD;
      mstep_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      mstep_r <= mstep_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide or compare two fractions, euclid reduction
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  input    | in_action, in_a_num/den, in_b_num/den   | start && !busy
//  result   | out_res_num/den, out_is_less/equal,     | out_valid, 1 cycle
//           | out_status                              |
//
//  one transaction at a time: multiply steps, a forming step, then a
//  remainder pass per euclid step and two final divides, each pass on
//  the bit-serial divider
//  compare, unused actions and zero denominators skip the divides
//  reset (synchronous, active low) returns the sequencer to idle
//  results cannot be stalled: out_valid is high for exactly one cycle
//
module rational_arithmetic_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_action,
  input  logic signed [rau_pkg::OPW-1:0]  in_a_num,
  input  logic signed [rau_pkg::OPW-1:0]  in_a_den,
  input  logic signed [rau_pkg::OPW-1:0]  in_b_num,
  input  logic signed [rau_pkg::OPW-1:0]  in_b_den,
  output logic                            out_valid,
  output logic signed [rau_pkg::RESW-1:0] out_res_num,
  output logic signed [rau_pkg::RESW-1:0] out_res_den,
  output logic                            out_is_less,
  output logic                            out_is_equal,
  output logic                            out_status
);
  import rau_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer
  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd),
    .sts   (sts)
  );

  // datapath, results held in registers until the next transaction
  rau_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_action),
    .in_a_num  (in_a_num),
    .in_a_den  (in_a_den),
    .in_b_num  (in_b_num),
    .in_b_den  (in_b_den),
    .res_num   (out_res_num),
    .res_den   (out_res_den),
    .is_less   (out_is_less),
    .is_equal  (out_is_equal),
    .status    (out_status)
  );

endmodule

// ===== hdl/rau_chk.sv =====
// ----------------------------------------------------------------------------
// rau_chk
// port-level checks on the rational arithmetic unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic signed [rau_pkg::RESW-1:0] out_res_num,
  input logic signed [rau_pkg::RESW-1:0] out_res_den,
  input logic                            out_is_less,
  input logic                            out_is_equal,
  input logic                            out_status
);

  `CHK_NEXT(a_start_busy, start && !busy, busy, "accepted transaction not busy")
  `CHK_NEXT(a_valid_pulse, out_valid, !out_valid && !busy, "result not a single pulse")
  `CHK_ALWAYS(a_valid_busy, !out_valid || busy, "result outside transaction")
  `CHK_ALWAYS(a_flags, !out_valid || !(out_is_less && out_is_equal), "less and equal both set")
  `CHK_ALWAYS(a_err_zero, !(out_valid && out_status) || (out_res_num == '0 && out_res_den == '0),
              "error result not zero")

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (.*);
